// ===== hw/rtl/swfl_pkg.sv =====
package swfl_pkg;

    localparam int FRAME_DEPTH = 64;
    localparam int FRAME_AW = 6;
    localparam int FRAME_LW = 7;
    localparam logic [FRAME_LW-1:0] FRAME_FILL_MAX = 7'd63;
    localparam logic [FRAME_LW-1:0] FRAME_HDR_LEN = 7'd2;
    localparam int PAYLOAD_MAX_DEF = 32;
    localparam int APB_AW = 3;

    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;
    localparam logic [APB_AW-1:0] REG_ACK_TIMEOUT = 3'd0;

    localparam logic [7:0] BYTE_START = 8'h7B;
    localparam logic [7:0] BYTE_END = 8'h7D;
    localparam logic [7:0] BYTE_ESC = 8'h5C;

    localparam logic [1:0] FUNC_REQ = 2'd0;
    localparam logic [1:0] FUNC_RX = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;
    localparam logic [1:0] FUNC_FETCH = 2'd3;

    localparam logic [2:0] KIND_LINK = 3'd0;
    localparam logic [2:0] KIND_REPLY = 3'd1;
    localparam logic [2:0] KIND_REFUSED = 3'd2;
    localparam logic [2:0] KIND_NOREPLY = 3'd3;
    localparam logic [2:0] KIND_EMPTY = 3'd4;

    typedef struct packed {
        logic                we;
        logic [FRAME_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic                re;
        logic [FRAME_AW-1:0] raddr;
    } mem_req_t;

endpackage

// ===== hw/rtl/swfl_ram.sv =====
module swfl_ram #(
    parameter int DEPTH = swfl_pkg::FRAME_DEPTH
) (
    input  logic              aclk,
    input  swfl_pkg::mem_req_t req,
    output logic [7:0]        rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/swfl_ctrl.sv =====
module swfl_ctrl #(
    parameter int PAYLOAD_MAX = swfl_pkg::PAYLOAD_MAX_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [15:0]        ack_timeout,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [7:0]         s_data_byte,
    input  logic               s_is_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_out_kind,
    output logic [7:0]         m_out_byte,
    output logic               m_out_last,
    output swfl_pkg::mem_req_t frame_req,
    input  logic [7:0]         frame_rdata,
    output swfl_pkg::mem_req_t reply_req,
    input  logic [7:0]         reply_rdata
);

    localparam int RLW = $clog2(PAYLOAD_MAX + 1);
    localparam int AW = swfl_pkg::FRAME_AW;
    localparam int LW = swfl_pkg::FRAME_LW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WR2 = 3'd1;
    localparam logic [2:0] ST_ONE = 3'd2;
    localparam logic [2:0] ST_TX = 3'd3;
    localparam logic [2:0] ST_RX = 3'd4;

    localparam logic [1:0] RX_HUNT = 2'd0;
    localparam logic [1:0] RX_SEQ = 2'd1;
    localparam logic [1:0] RX_PAY = 2'd2;

    logic [2:0]     state_reg, state_next;
    logic           seq_reg, seq_next;
    logic [LW-1:0]  frame_len_reg, frame_len_next;
    logic           outst_reg, outst_next;
    logic [15:0]    ticks_reg, ticks_next;
    logic [RLW-1:0] reply_len_reg, reply_len_next;
    logic [1:0]     rx_phase_reg, rx_phase_next;
    logic           esc_reg, esc_next;
    logic           complete_reg, complete_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [7:0]     pend_byte_reg, pend_byte_next;
    logic           pend_last_reg, pend_last_next;
    logic [2:0]     pend_kind_reg, pend_kind_next;
    logic           m_valid_reg, m_valid_next;
    logic [2:0]     m_kind_reg, m_kind_next;
    logic [7:0]     m_byte_reg, m_byte_next;
    logic           m_last_reg, m_last_next;

    logic           acc;
    logic           out_free;
    logic           start_tx;
    logic           rx_store;
    logic           rx_drop;
    logic [LW-1:0]  fl;
    logic           need2;
    logic           fits;
    logic [15:0]    ticks_inc;
    logic [7:0]     tx_byte;
    logic           tx_last;
    logic           rx_last;

    assign s_ready = (state_reg == ST_IDLE);
    assign acc = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign fl = (frame_len_reg < swfl_pkg::FRAME_HDR_LEN) ? swfl_pkg::FRAME_HDR_LEN
                                                           : frame_len_reg;
    assign need2 = (s_data_byte == swfl_pkg::BYTE_END) || (s_data_byte == swfl_pkg::BYTE_ESC);
    assign fits = (fl + (need2 ? LW'(2) : LW'(1))) <= swfl_pkg::FRAME_FILL_MAX;
    assign ticks_inc = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;

    assign tx_last = ({1'b0, idx_reg} == frame_len_reg);
    assign rx_last = (idx_reg == (AW'(reply_len_reg) - AW'(1)));

    always_comb begin
        if (idx_reg == AW'(0)) begin
            tx_byte = swfl_pkg::BYTE_START;
        end else if (idx_reg == AW'(1)) begin
            tx_byte = {7'd0, seq_reg};
        end else if (tx_last) begin
            tx_byte = swfl_pkg::BYTE_END;
        end else begin
            tx_byte = frame_rdata;
        end
    end

    always_comb begin
        state_next = state_reg;
        seq_next = seq_reg;
        frame_len_next = frame_len_reg;
        outst_next = outst_reg;
        ticks_next = ticks_reg;
        reply_len_next = reply_len_reg;
        rx_phase_next = rx_phase_reg;
        esc_next = esc_reg;
        complete_next = complete_reg;
        idx_next = idx_reg;
        pend_byte_next = pend_byte_reg;
        pend_last_next = pend_last_reg;
        pend_kind_next = pend_kind_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next = m_kind_reg;
        m_byte_next = m_byte_reg;
        m_last_next = m_last_reg;
        frame_req = '0;
        reply_req = '0;
        start_tx = 1'b0;
        rx_store = 1'b0;
        rx_drop = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    case (s_func)
                        swfl_pkg::FUNC_REQ: begin
                            if (outst_reg) begin
                                pend_kind_next = swfl_pkg::KIND_REFUSED;
                                state_next = ST_ONE;
                            end else begin
                                frame_len_next = fl;
                                if (fits && need2) begin
                                    frame_req.we = 1'b1;
                                    frame_req.waddr = fl[AW-1:0];
                                    frame_req.wdata = swfl_pkg::BYTE_ESC;
                                    frame_len_next = fl + LW'(1);
                                    pend_byte_next = s_data_byte;
                                    pend_last_next = s_is_last;
                                    state_next = ST_WR2;
                                end else begin
                                    if (fits) begin
                                        frame_req.we = 1'b1;
                                        frame_req.waddr = fl[AW-1:0];
                                        frame_req.wdata = s_data_byte;
                                        frame_len_next = fl + LW'(1);
                                    end
                                    start_tx = s_is_last;
                                end
                            end
                        end
                        swfl_pkg::FUNC_RX: begin
                            if (!complete_reg) begin
                                case (rx_phase_reg)
                                    RX_SEQ: begin
                                        if (s_data_byte == {7'd0, seq_reg}) begin
                                            rx_phase_next = RX_PAY;
                                            esc_next = 1'b0;
                                            reply_len_next = '0;
                                        end else begin
                                            rx_drop = 1'b1;
                                        end
                                    end
                                    RX_PAY: begin
                                        if (esc_reg) begin
                                            esc_next = 1'b0;
                                            if (need2) begin
                                                rx_store = 1'b1;
                                            end else begin
                                                rx_drop = 1'b1;
                                            end
                                        end else if (s_data_byte == swfl_pkg::BYTE_ESC) begin
                                            esc_next = 1'b1;
                                        end else if (s_data_byte == swfl_pkg::BYTE_END) begin
                                            complete_next = 1'b1;
                                            rx_phase_next = RX_HUNT;
                                        end else begin
                                            rx_store = 1'b1;
                                        end
                                    end
                                    default: begin
                                        if (s_data_byte == swfl_pkg::BYTE_START) begin
                                            rx_phase_next = RX_SEQ;
                                            esc_next = 1'b0;
                                            reply_len_next = '0;
                                        end else begin
                                            rx_phase_next = RX_HUNT;
                                        end
                                    end
                                endcase
                            end
                        end
                        swfl_pkg::FUNC_TICK: begin
                            if (outst_reg && !complete_reg) begin
                                if (ticks_inc > ack_timeout) begin
                                    ticks_next = '0;
                                    idx_next = '0;
                                    frame_req.re = 1'b1;
                                    frame_req.raddr = '0;
                                    state_next = ST_TX;
                                end else begin
                                    ticks_next = ticks_inc;
                                end
                            end
                        end
                        default: begin
                            if (!complete_reg) begin
                                pend_kind_next = swfl_pkg::KIND_NOREPLY;
                                state_next = ST_ONE;
                            end else begin
                                complete_next = 1'b0;
                                seq_next = !seq_reg;
                                outst_next = 1'b0;
                                frame_len_next = '0;
                                ticks_next = '0;
                                if (reply_len_reg == '0) begin
                                    pend_kind_next = swfl_pkg::KIND_EMPTY;
                                    state_next = ST_ONE;
                                end else begin
                                    idx_next = '0;
                                    reply_req.re = 1'b1;
                                    reply_req.raddr = '0;
                                    state_next = ST_RX;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_WR2: begin
                frame_req.we = 1'b1;
                frame_req.waddr = frame_len_reg[AW-1:0];
                frame_req.wdata = pend_byte_reg;
                frame_len_next = frame_len_reg + LW'(1);
                if (pend_last_reg) begin
                    start_tx = 1'b1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next = pend_kind_reg;
                    m_byte_next = '0;
                    m_last_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TX: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next = swfl_pkg::KIND_LINK;
                    m_byte_next = tx_byte;
                    m_last_next = tx_last;
                    if (tx_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + AW'(1);
                        frame_req.re = 1'b1;
                        frame_req.raddr = idx_reg + AW'(1);
                    end
                end
            end
            ST_RX: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next = swfl_pkg::KIND_REPLY;
                    m_byte_next = reply_rdata;
                    m_last_next = rx_last;
                    if (rx_last) begin
                        reply_len_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + AW'(1);
                        reply_req.re = 1'b1;
                        reply_req.raddr = idx_reg + AW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (start_tx) begin
            outst_next = 1'b1;
            ticks_next = '0;
            idx_next = '0;
            frame_req.re = 1'b1;
            frame_req.raddr = '0;
            state_next = ST_TX;
        end

        if (rx_store) begin
            if (reply_len_reg >= RLW'(PAYLOAD_MAX)) begin
                rx_drop = 1'b1;
            end else begin
                reply_req.we = 1'b1;
                reply_req.waddr = AW'(reply_len_reg);
                reply_req.wdata = s_data_byte;
                reply_len_next = reply_len_reg + RLW'(1);
            end
        end

        if (rx_drop) begin
            rx_phase_next = RX_HUNT;
            esc_next = 1'b0;
            reply_len_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seq_reg <= 1'b0;
            frame_len_reg <= '0;
            outst_reg <= 1'b0;
            ticks_reg <= '0;
            reply_len_reg <= '0;
            rx_phase_reg <= RX_HUNT;
            esc_reg <= 1'b0;
            complete_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            seq_reg <= seq_next;
            frame_len_reg <= frame_len_next;
            outst_reg <= outst_next;
            ticks_reg <= ticks_next;
            reply_len_reg <= reply_len_next;
            rx_phase_reg <= rx_phase_next;
            esc_reg <= esc_next;
            complete_reg <= complete_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        pend_byte_reg <= pend_byte_next;
        pend_last_reg <= pend_last_next;
        pend_kind_reg <= pend_kind_next;
        m_kind_reg <= m_kind_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_out_kind = m_kind_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;

endmodule

// ===== hw/rtl/stop_wait_framed_link_unit.sv =====
// Stop-and-wait link engine with byte-stuffed framing. A request byte that
// needs an escape writes its byte in a second state, since the frame memory
// has one write port. A sent frame (on the last request byte or on a timeout
// tick) or a fetched reply streams out one item per cycle while the output does
// not stall, after a registered memory read. Single-result items (refused, no
// reply, empty reply) pass through their own output state. No item is accepted
// while a frame or reply is streaming. No clearing pass after reset.
module stop_wait_framed_link_unit #(
    parameter int PAYLOAD_MAX = swfl_pkg::PAYLOAD_MAX_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swfl_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_func,
    input  logic [7:0]                  s_data_byte,
    input  logic                        s_is_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_out_kind,
    output logic [7:0]                  m_out_byte,
    output logic                        m_out_last
);

    logic [15:0]        ack_timeout_reg, ack_timeout_next;
    logic               reg_sel;
    swfl_pkg::mem_req_t frame_req;
    swfl_pkg::mem_req_t reply_req;
    logic [7:0]         frame_rdata;
    logic [7:0]         reply_rdata;

    assign pready = 1'b1;
    assign reg_sel = (paddr[swfl_pkg::APB_AW-1:2] == swfl_pkg::REG_ACK_TIMEOUT[swfl_pkg::APB_AW-1:2]);

    always_comb begin
        ack_timeout_next = ack_timeout_reg;
        if (psel && penable && pwrite && reg_sel) begin
            ack_timeout_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg <= swfl_pkg::ACK_TIMEOUT_RST;
        end else begin
            ack_timeout_reg <= ack_timeout_next;
        end
    end

    assign prdata = reg_sel ? {16'd0, ack_timeout_reg} : 32'd0;

    swfl_ram #(
        .DEPTH(swfl_pkg::FRAME_DEPTH)
    ) u_frame_ram (
        .aclk  (aclk),
        .req   (frame_req),
        .rdata (frame_rdata)
    );

    swfl_ram #(
        .DEPTH(PAYLOAD_MAX)
    ) u_reply_ram (
        .aclk  (aclk),
        .req   (reply_req),
        .rdata (reply_rdata)
    );

    swfl_ctrl #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ack_timeout (ack_timeout_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_data_byte (s_data_byte),
        .s_is_last   (s_is_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_kind  (m_out_kind),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last),
        .frame_req   (frame_req),
        .frame_rdata (frame_rdata),
        .reply_req   (reply_req),
        .reply_rdata (reply_rdata)
    );

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_kind != swfl_pkg::KIND_LINK) && (m_out_kind != swfl_pkg::KIND_REPLY)
        |-> m_out_last && (m_out_byte == 8'd0))
        else $error("status item not single and zero");

    a_hdr_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_req.we |-> (frame_req.waddr >= 6'd2))
        else $error("payload write into header slot");

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        reply_req.we |-> !frame_req.we && !frame_req.re && !reply_req.re)
        else $error("reply write overlaps other memory access");

    a_rw_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_req.we && frame_req.re |-> (frame_req.waddr != frame_req.raddr))
        else $error("frame memory read and write hit one entry");

endmodule

// ===== sim/tb_stop_wait_framed_link_unit.sv =====
`timescale 1ns / 100ps

module tb_stop_wait_framed_link_unit;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 28;

    typedef enum logic [1:0] {
        RX_HUNT = 2'd0,
        RX_SEQ  = 2'd1,
        RX_BODY = 2'd2
    } rx_state_e;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       is_last;
    } link_result_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data;
        logic       is_last;
        logic       has_ref;
        logic [2:0] ref_kind;
        logic [7:0] ref_byte;
    } stim_item_t;

    localparam int DIRECTED_N = 27;
    localparam stim_item_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{swfl_pkg::FUNC_FETCH, 8'h00, 1'b0, 1'b1, swfl_pkg::KIND_NOREPLY, 8'h00},
        '{swfl_pkg::FUNC_REQ,   8'h00, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_REQ,   8'h7D, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_REQ,   8'h5C, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_REQ,   8'hFF, 1'b1, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_REQ,   8'h7B, 1'b0, 1'b1, swfl_pkg::KIND_REFUSED, 8'h00},
        '{swfl_pkg::FUNC_TICK,  8'hFF, 1'b1, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h7B, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h01, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h7B, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h00, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h5C, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h41, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h7B, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h00, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h7D, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h22, 1'b1, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_TICK,  8'h00, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_FETCH, 8'hA5, 1'b1, 1'b1, swfl_pkg::KIND_EMPTY,   8'h00},
        '{swfl_pkg::FUNC_REQ,   8'h80, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h7B, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h01, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h7B, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h5C, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h5C, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_RX,    8'h7D, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00},
        '{swfl_pkg::FUNC_FETCH, 8'h00, 1'b0, 1'b0, swfl_pkg::KIND_LINK,    8'h00}
    };

    logic                          aclk;
    logic                          aresetn;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [swfl_pkg::APB_AW-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          s_valid;
    logic                          s_ready;
    logic [1:0]                    s_func;
    logic [7:0]                    s_data_byte;
    logic                          s_is_last;
    logic                          m_valid;
    logic                          m_ready;
    logic [2:0]                    m_out_kind;
    logic [7:0]                    m_out_byte;
    logic                          m_out_last;

    // link engine state as the testbench sees it
    logic [15:0]                   cfg_ack_timeout;
    logic                          seq_bit;
    logic [7:0]                    frame_bytes [swfl_pkg::FRAME_DEPTH];
    logic [swfl_pkg::FRAME_LW-1:0] frame_len;
    logic                          req_pending;
    logic [15:0]                   tick_count;
    logic [7:0]                    reply_bytes [swfl_pkg::PAYLOAD_MAX_DEF];
    logic [5:0]                    reply_len;
    rx_state_e                     rx_state;
    logic                          rx_esc;
    logic                          reply_done;

    link_result_t                  step_out [$];
    link_result_t                  expected_results [$];
    stim_item_t                    stim_q [$];
    stim_item_t                    drv_item;

    int                            queued_items;
    int                            accepted_items;
    int                            results_seen;
    int                            error_count;
    int                            cycle_count;
    int                            refusals;
    int                            resends;
    int                            frame_drops;
    int                            replies_fetched;
    int                            timeout_settings;

    stop_wait_framed_link_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_data_byte (s_data_byte),
        .s_is_last   (s_is_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_kind  (m_out_kind),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endfunction

    // ---------------- predictor ----------------

    function automatic void emit(logic [2:0] kind, logic [7:0] value);
        step_out.push_back('{kind, value, 1'b0});
    endfunction

    function automatic void close_run();
        if (step_out.size() > 0) begin
            step_out[step_out.size() - 1].is_last = 1'b1;
        end
    endfunction

    function automatic void emit_frame();
        for (int i = 0; i < frame_len && i < swfl_pkg::FRAME_DEPTH - 1; i++) begin
            emit(swfl_pkg::KIND_LINK, frame_bytes[i]);
        end
        emit(swfl_pkg::KIND_LINK, swfl_pkg::BYTE_END);
        close_run();
    endfunction

    function automatic void rx_drop();
        rx_state = RX_HUNT;
        rx_esc = 1'b0;
        reply_len = '0;
    endfunction

    function automatic void rx_keep(logic [7:0] b);
        if (reply_len >= swfl_pkg::PAYLOAD_MAX_DEF) begin
            rx_drop();
        end else begin
            reply_bytes[reply_len] = b;
            reply_len++;
        end
    endfunction

    function automatic void link_rx(logic [7:0] b);
        if (reply_done) begin
            return;
        end
        case (rx_state)
            RX_SEQ: begin
                if (b == {7'd0, seq_bit}) begin
                    rx_state = RX_BODY;
                    rx_esc = 1'b0;
                    reply_len = '0;
                end else begin
                    rx_drop();
                end
            end
            RX_BODY: begin
                if (rx_esc) begin
                    rx_esc = 1'b0;
                    if (b == swfl_pkg::BYTE_ESC || b == swfl_pkg::BYTE_END) begin
                        rx_keep(b);
                    end else begin
                        rx_drop();
                    end
                end else if (b == swfl_pkg::BYTE_ESC) begin
                    rx_esc = 1'b1;
                end else if (b == swfl_pkg::BYTE_END) begin
                    reply_done = 1'b1;
                    rx_state = RX_HUNT;
                end else begin
                    rx_keep(b);
                end
            end
            default: begin
                if (b == swfl_pkg::BYTE_START) begin
                    rx_state = RX_SEQ;
                    rx_esc = 1'b0;
                    reply_len = '0;
                end else begin
                    rx_state = RX_HUNT;
                end
            end
        endcase
    endfunction

    function automatic void link_predict(logic [1:0] func, logic [7:0] b, logic is_last);
        int need;
        case (func)
            swfl_pkg::FUNC_REQ: begin
                if (req_pending) begin
                    emit(swfl_pkg::KIND_REFUSED, 8'h00);
                    close_run();
                    refusals++;
                end else begin
                    if (frame_len < swfl_pkg::FRAME_HDR_LEN) begin
                        frame_bytes[0] = swfl_pkg::BYTE_START;
                        frame_bytes[1] = {7'd0, seq_bit};
                        frame_len = swfl_pkg::FRAME_HDR_LEN;
                    end
                    need = (b == swfl_pkg::BYTE_END || b == swfl_pkg::BYTE_ESC) ? 2 : 1;
                    if (frame_len + need <= swfl_pkg::FRAME_FILL_MAX) begin
                        if (need == 2) begin
                            frame_bytes[frame_len] = swfl_pkg::BYTE_ESC;
                            frame_len++;
                        end
                        frame_bytes[frame_len] = b;
                        frame_len++;
                    end else begin
                        frame_drops++;
                    end
                    if (is_last) begin
                        req_pending = 1'b1;
                        tick_count = '0;
                        emit_frame();
                    end
                end
            end
            swfl_pkg::FUNC_RX: begin
                link_rx(b);
            end
            swfl_pkg::FUNC_TICK: begin
                if (req_pending && !reply_done) begin
                    if (tick_count != 16'hFFFF) begin
                        tick_count++;
                    end
                    if (tick_count > cfg_ack_timeout) begin
                        tick_count = '0;
                        resends++;
                        emit_frame();
                    end
                end
            end
            default: begin
                if (!reply_done) begin
                    emit(swfl_pkg::KIND_NOREPLY, 8'h00);
                end else begin
                    reply_done = 1'b0;
                    seq_bit = ~seq_bit;
                    req_pending = 1'b0;
                    frame_len = '0;
                    tick_count = '0;
                    for (int i = 0; i < reply_len; i++) begin
                        emit(swfl_pkg::KIND_REPLY, reply_bytes[i]);
                    end
                    if (reply_len == 0) begin
                        emit(swfl_pkg::KIND_EMPTY, 8'h00);
                    end
                    reply_len = '0;
                    replies_fetched++;
                end
                close_run();
            end
        endcase
    endfunction

    // ---------------- stimulus ----------------

    function automatic void queue_item(logic [1:0] func, logic [7:0] data, logic is_last);
        stim_q.push_back('{func, data, is_last, 1'b0, swfl_pkg::KIND_LINK, 8'h00});
        queued_items++;
    endfunction

    function automatic logic [7:0] pick_byte(bit heavy);
        int sel;
        sel = $urandom_range(0, heavy ? 3 : 9);
        case (sel)
            0: return swfl_pkg::BYTE_END;
            1: return swfl_pkg::BYTE_ESC;
            2: return swfl_pkg::BYTE_START;
            default: return heavy ? swfl_pkg::BYTE_END : 8'($urandom);
        endcase
    endfunction

    // one request / reply / fetch exchange, shaped from the current state
    function automatic void queue_exchange();
        int len;
        bit heavy;
        logic [7:0] b;
        if (!req_pending || $urandom_range(0, 5) == 0) begin
            heavy = ($urandom_range(0, 9) == 0);
            len = heavy ? $urandom_range(30, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                queue_item(swfl_pkg::FUNC_REQ, pick_byte(heavy), i == len - 1);
            end
        end
        len = $urandom_range(0, 5);
        for (int i = 0; i < len; i++) begin
            queue_item(swfl_pkg::FUNC_TICK, 8'($urandom), 1'($urandom));
        end
        if ($urandom_range(0, 6) != 0) begin
            if ($urandom_range(0, 5) == 0) begin
                queue_item(swfl_pkg::FUNC_RX, 8'($urandom), 1'($urandom));
            end
            queue_item(swfl_pkg::FUNC_RX, swfl_pkg::BYTE_START, 1'b0);
            if ($urandom_range(0, 7) == 0) begin
                queue_item(swfl_pkg::FUNC_RX, {7'd0, ~seq_bit}, 1'b0);
            end else begin
                queue_item(swfl_pkg::FUNC_RX, {7'd0, seq_bit}, 1'b0);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 8);
            for (int i = 0; i < len; i++) begin
                b = pick_byte(1'b0);
                if ($urandom_range(0, 39) == 0) begin
                    queue_item(swfl_pkg::FUNC_RX, swfl_pkg::BYTE_ESC, 1'b0);
                    queue_item(swfl_pkg::FUNC_RX, 8'h41, 1'b0);
                end else if (b == swfl_pkg::BYTE_END || b == swfl_pkg::BYTE_ESC) begin
                    queue_item(swfl_pkg::FUNC_RX, swfl_pkg::BYTE_ESC, 1'b0);
                    queue_item(swfl_pkg::FUNC_RX, b, 1'($urandom));
                end else begin
                    queue_item(swfl_pkg::FUNC_RX, b, 1'($urandom));
                end
            end
            if ($urandom_range(0, 9) != 0) begin
                queue_item(swfl_pkg::FUNC_RX, swfl_pkg::BYTE_END, 1'b0);
            end
        end
        len = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            queue_item(swfl_pkg::FUNC_TICK, 8'($urandom), 1'($urandom));
        end
        if ($urandom_range(0, 9) != 0) begin
            queue_item(swfl_pkg::FUNC_FETCH, 8'($urandom), 1'($urandom));
        end
        if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                queue_item(2'($urandom), 8'($urandom), 1'($urandom));
            end
        end
    endfunction

    task automatic wait_idle();
        while (accepted_items != queued_items || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_ack_timeout(logic [15:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= swfl_pkg::REG_ACK_TIMEOUT;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[15:0] !== value) begin
            flag_error($sformatf("ack_timeout read %0d, expected %0d", prdata[15:0], value));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_ack_timeout(logic [15:0] value);
        wait_idle();
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= swfl_pkg::REG_ACK_TIMEOUT;
        pwdata <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        cfg_ack_timeout = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        timeout_settings++;
        check_ack_timeout(value);
    endtask

    // ---------------- sender ----------------

    initial begin
        stim_item_t nxt;
        int burst_left;
        int gap_left;
        burst_left = $urandom_range(1, 16);
        gap_left = 0;
        s_valid <= 1'b0;
        s_func <= swfl_pkg::FUNC_TICK;
        s_data_byte <= '0;
        s_is_last <= 1'b0;
        drv_item <= '0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    s_valid <= 1'b0;
                    gap_left--;
                end else if (stim_q.size() > 0) begin
                    nxt = stim_q.pop_front();
                    drv_item <= nxt;
                    s_func <= nxt.func;
                    s_data_byte <= nxt.data;
                    s_is_last <= nxt.is_last;
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver ----------------

    initial begin
        bit held_off;
        int mode;
        int mode_left;
        held_off = 1'b0;
        mode = 0;
        mode_left = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!held_off && results_seen >= 60) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 99) >= 35);
                    2: m_ready <= mode_left[0];
                    default: m_ready <= ($urandom_range(0, 99) >= 80);
                endcase
            end
        end
    end

    // ---------------- checker ----------------

    always @(posedge aclk) begin
        link_result_t got;
        link_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_out_kind, m_out_byte, m_out_last};
                results_seen++;
                if (expected_results.size() == 0) begin
                    flag_error($sformatf("unexpected item kind %0d byte %02h last %0b",
                        got.kind, got.value, got.is_last));
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value
                            || got.is_last !== want.is_last) begin
                        flag_error($sformatf(
                            "item %0d: expected kind %0d byte %02h last %0b, got %0d %02h %0b",
                            results_seen, want.kind, want.value, want.is_last,
                            got.kind, got.value, got.is_last));
                    end
                end
            end
            if (s_valid && s_ready) begin
                accepted_items++;
                step_out.delete();
                link_predict(s_func, s_data_byte, s_is_last);
                if (drv_item.has_ref) begin
                    expected_results.push_back('{drv_item.ref_kind, drv_item.ref_byte, 1'b1});
                end else begin
                    foreach (step_out[k]) expected_results.push_back(step_out[k]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        logic [15:0] phase_timeouts [4];
        int target;
        queued_items = 0;
        accepted_items = 0;
        results_seen = 0;
        error_count = 0;
        cycle_count = 0;
        refusals = 0;
        resends = 0;
        frame_drops = 0;
        replies_fetched = 0;
        timeout_settings = 0;
        cfg_ack_timeout = swfl_pkg::ACK_TIMEOUT_RST;
        seq_bit = 1'b0;
        frame_len = '0;
        req_pending = 1'b0;
        tick_count = '0;
        reply_len = '0;
        rx_state = RX_HUNT;
        rx_esc = 1'b0;
        reply_done = 1'b0;
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        check_ack_timeout(swfl_pkg::ACK_TIMEOUT_RST);
        set_ack_timeout(16'd0);
        foreach (DIRECTED_ROWS[i]) begin
            stim_q.push_back(DIRECTED_ROWS[i]);
            queued_items++;
        end

        phase_timeouts = '{16'hFFFF, 16'd3, 16'($urandom_range(1, 40)), 16'd0};
        target = queued_items;
        foreach (phase_timeouts[p]) begin
            set_ack_timeout(phase_timeouts[p]);
            target += PHASE_ITEMS;
            while (queued_items < target) begin
                queue_exchange();
                while (accepted_items != queued_items) @(posedge aclk);
            end
        end
        wait_idle();

        $display("Covered %0d items in, %0d items out, %0d timeout settings, %0d resends,",
            accepted_items, results_seen, timeout_settings, resends);
        $display("%0d refused requests, %0d frame-full drops, %0d replies fetched.",
            refusals, frame_drops, replies_fetched);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
